FILE: design/trq_pkg.sv
// trq_pkg: types and constants shared by the timestamp reorder queue
// stored entry layout, status codes and sizing of the sorted store
// no dependencies

package trq_pkg;

	localparam int DEPTH = 8;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int TS_W = 63;
	localparam int ID_W = 16;
	localparam int THR_W = 4;
	localparam int OCC_W = 4;
	localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP = 1'b1;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_NONE = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic [TS_W-1:0] ts;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/trq_ram.sv
// trq_ram: generic single write, single read port ram with registered read
// used for the sorted entry store; no dependencies

module trq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/timestamp_reorder_queue_unit.sv
// timestamp_reorder_queue_unit: presentation timestamp reorder buffer
// depends on trq_pkg and trq_ram
// usage:
//   input stream s_*: one item is a push (s_tuser low) of a timestamp and frame
//   handle, or a pop (s_tuser high) of the earliest frame; s_tlast is the
//   end-of-stream flag, which lets a pop release below the threshold
//   output stream m_*: exactly one result item per input item, in order
//   cfg_we / cfg_wdata set the release threshold; the user must write it only while idle, the block does not enforce it
// timing:
//   entries sit sorted in a ram with one read and one write port; a single
//   timestamp comparator walks the store for a push, one entry at a time,
//   each entry read and then compared
//   s_tready rises the cycle after the result loads, so a new item is only taken
//   once the result of the last one has moved to the output register
// reset: queue empty, threshold 5, no result pending; ram contents not cleared
// stall:
//   a finished result waits in the output register; the next item is taken
//   and worked on, and its result waits until the register frees up

module timestamp_reorder_queue_unit
	import trq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [79:0]      s_tdata,   // timestamp[62:0], frame_id[78:63], zero pad
	input  logic             s_tuser,   // op
	input  logic             s_tlast,   // end_of_stream
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [87:0]      m_tdata,   // out_timestamp[62:0], out_frame_id[78:63],
	                                    // occupancy[82:79], zero pad
	output logic [1:0]       m_tuser,   // status
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRD,
		S_PCMP,
		S_PINS,
		S_QRD0,
		S_QHEAD,
		S_QRD,
		S_QMV
	} state_t;

	state_t           state_q;
	logic             done_q;
	logic [TS_W-1:0]  ts_q;
	logic [ID_W-1:0]  id_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] count_q;
	logic [THR_W-1:0] thr_q;
	status_t          res_status_q;
	entry_t           res_q;
	logic             m_tvalid_q;
	status_t          out_status_q;
	entry_t           out_entry_q;
	logic [OCC_W-1:0] out_occ_q;

	entry_t           rd_entry;
	logic [ENTRY_W-1:0] rd_data;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	logic             ts_le;
	logic             accept;
	logic             load_out;
	logic             in_op;
	logic             in_eos;
	entry_t           in_entry;

	assign in_entry = entry_t'(s_tdata[ENTRY_W-1:0]);
	assign in_op = s_tuser;
	assign in_eos = s_tlast;
	assign rd_entry = entry_t'(rd_data);
	assign s_tready = (state_q == S_IDLE) && !done_q;
	assign accept = s_tvalid && s_tready;
	assign load_out = done_q && (!m_tvalid_q || m_tready);

	// single timestamp comparator, used by the push walk
	assign ts_le = (ts_q <= rd_entry.ts);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = rd_entry;
		case (state_q)
			S_PCMP: begin
				ram_we = 1'b1;
				ram_waddr = idx_q + IDX_W'(1);
				if (!ts_le) begin
					ram_wdata = '{id: id_q, ts: ts_q};
				end
			end
			S_PINS: begin
				ram_we = 1'b1;
				ram_wdata = '{id: id_q, ts: ts_q};
			end
			S_QMV: begin
				ram_we = 1'b1;
				ram_waddr = idx_q - IDX_W'(1);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	trq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			idx_q <= '0;
			count_q <= '0;
			thr_q <= THR_RESET;
			res_status_q <= ST_NONE;
			m_tvalid_q <= 1'b0;
			out_status_q <= ST_NONE;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
				out_status_q <= res_status_q;
				out_entry_q <= res_q;
				out_occ_q <= OCC_W'(count_q);
				done_q <= 1'b0;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						ts_q <= in_entry.ts;
						id_q <= in_entry.id;
						res_q <= '0;
						if (in_op == OP_PUSH) begin
							if (count_q == CNT_W'(DEPTH)) begin
								res_status_q <= ST_FULL;
								done_q <= 1'b1;
							end else if (count_q == '0) begin
								idx_q <= '0;
								state_q <= S_PINS;
							end else begin
								idx_q <= IDX_W'(count_q - CNT_W'(1));
								state_q <= S_PRD;
							end
						end else begin
							if (count_q == '0 ||
							    (!in_eos && CMP_W'(count_q) < CMP_W'(thr_q))) begin
								res_status_q <= ST_NONE;
								done_q <= 1'b1;
							end else begin
								idx_q <= '0;
								state_q <= S_QRD0;
							end
						end
					end
				end
				S_PRD: begin
					state_q <= S_PCMP;
				end
				S_PCMP: begin
					if (ts_le) begin
						if (idx_q == '0) begin
							state_q <= S_PINS;
						end else begin
							idx_q <= idx_q - IDX_W'(1);
							state_q <= S_PRD;
						end
					end else begin
						count_q <= count_q + CNT_W'(1);
						res_status_q <= ST_PUSHED;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_PINS: begin
					count_q <= count_q + CNT_W'(1);
					res_status_q <= ST_PUSHED;
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_QRD0: begin
					state_q <= S_QHEAD;
				end
				S_QHEAD: begin
					res_q <= rd_entry;
					res_status_q <= ST_POPPED;
					if (count_q == CNT_W'(1)) begin
						count_q <= count_q - CNT_W'(1);
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= IDX_W'(1);
						state_q <= S_QRD;
					end
				end
				S_QRD: begin
					state_q <= S_QMV;
				end
				S_QMV: begin
					if (CNT_W'(idx_q) == count_q - CNT_W'(1)) begin
						count_q <= count_q - CNT_W'(1);
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						state_q <= S_QRD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser = out_status_q;
	assign m_tdata = {5'd0, out_occ_q, out_entry_q};

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && res_status_q == ST_FULL) |-> count_q == CNT_W'(DEPTH))
		else $error("push dropped while store not full");

	a_read_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PCMP || state_q == S_QMV) |-> CNT_W'(idx_q) < count_q)
		else $error("store read beyond stored entries");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE || done_q))
		else $error("accepted item not taken up");
`endif

endmodule

FILE: verif/trq_checker.sv
// trq_checker: watches the item channels of the timestamp reorder queue,
// keeps its own sorted frame store and compares every result item in order
// depends on trq_pkg

module trq_checker
	import trq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [79:0]      s_tdata,
	input  logic             s_tuser,
	input  logic             s_tlast,
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [87:0]      m_tdata,
	input  logic [1:0]       m_tuser,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata,
	output int unsigned      mismatches,
	output int unsigned      outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t          status;
		logic [TS_W-1:0]  ts;
		logic [ID_W-1:0]  id;
		logic [OCC_W-1:0] occ;
	} release_t;

	entry_t           frames [DEPTH+1];
	int               frame_count;
	logic [THR_W-1:0] threshold;
	release_t         pending_releases [$];
	release_t         next_release;
	release_t         want;
	release_t         got;

	function automatic release_t order_frame(input logic op, input logic [TS_W-1:0] ts,
			input logic [ID_W-1:0] id, input logic eos);
		release_t r;
		int slot;
		int i;
		r.status = ST_PUSHED;
		r.ts = '0;
		r.id = '0;
		if (op == OP_PUSH) begin
			if (frame_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				slot = frame_count;
				for (i = frame_count - 1; i >= 0; i--)
					if (ts <= frames[i].ts)
						slot = i;
				for (i = frame_count; i > slot; i--)
					frames[i] = frames[i-1];
				frames[slot].ts = ts;
				frames[slot].id = id;
				frame_count++;
			end
		end else if (frame_count == 0 || (!eos && frame_count < int'(threshold))) begin
			r.status = ST_NONE;
		end else begin
			r.status = ST_POPPED;
			r.ts = frames[0].ts;
			r.id = frames[0].id;
			for (i = 1; i < frame_count; i++)
				frames[i-1] = frames[i];
			frame_count--;
		end
		r.occ = OCC_W'(frame_count);
		return r;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s expected %h got %h", $time, field, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count = 0;
			threshold = THR_RESET;
			pending_releases.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (cfg_we)
				threshold = cfg_wdata;
			if (s_tvalid && s_tready) begin
				next_release = order_frame(s_tuser, s_tdata[62:0], s_tdata[78:63], s_tlast);
				pending_releases.insert(pending_releases.size(), next_release);
			end
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.ts = m_tdata[62:0];
				got.id = m_tdata[78:63];
				got.occ = m_tdata[82:79];
				if (pending_releases.size() == 0) begin
					$display("%0t: unexpected item status %0d data %h", $time, m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = pending_releases[0];
					pending_releases.delete(0);
					check_field("status", 64'(want.status), 64'(got.status));
					check_field("out_timestamp", 64'(want.ts), 64'(got.ts));
					check_field("out_frame_id", 64'(want.id), 64'(got.id));
					check_field("occupancy", 64'(want.occ), 64'(got.occ));
				end
			end
			outstanding = pending_releases.size();
		end
	end

endmodule

FILE: verif/testbench.sv
// testbench: drives pushes and pops into timestamp_reorder_queue_unit with random
// gaps and stalls over several release thresholds and gives the verdict
// depends on trq_pkg, the block and trq_checker

module testbench
	import trq_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 205;
	localparam int HOLD_CYCLES = 120;
	localparam int DRAIN_CYCLES = 4 * DEPTH + 8;
	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam logic [TS_W-1:0] TS_MAX = '1;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [79:0]      s_tdata = '0;
	logic             s_tuser = OP_PUSH;
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [87:0]      m_tdata;
	logic [1:0]       m_tuser;
	logic             cfg_we = 1'b0;
	logic [THR_W-1:0] cfg_wdata = '0;

	int unsigned      mismatches;
	int unsigned      outstanding;
	int unsigned      cycles = 0;
	int               send_idle_pct = 17;
	int               recv_idle_pct = 55;
	logic             hold_req = 1'b0;
	logic             hold_seen = 1'b0;
	int               hold_left = 0;
	logic [TS_W-1:0]  stream_ts = '0;
	logic [THR_W-1:0] phase_thr [PHASES];

	timestamp_reorder_queue_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	trq_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// long hold-off so the output register fills and the input stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(input logic op, input logic [TS_W-1:0] ts,
			input logic [ID_W-1:0] id, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {1'b0, id, ts};
		s_tlast <= eos;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(input int count);
		int push_pct;
		int sel;
		int i;
		logic [TS_W-1:0] ts;
		push_pct = 50;
		for (i = 0; i < count; i++) begin
			if (i % 16 == 0)
				push_pct = $urandom_range(80, 25);
			sel = $urandom_range(9);
			if (sel < 5) begin
				stream_ts = stream_ts + TS_W'($urandom_range(1000, 1));
				ts = stream_ts + TS_W'($urandom_range(3000));
			end else if (sel < 7) begin
				ts = TS_W'({$urandom, $urandom});
			end else if (sel < 9) begin
				ts = TS_W'($urandom_range(7));
			end else begin
				ts = $urandom_range(1) ? TS_MAX : '0;
			end
			if ($urandom_range(99) < push_pct)
				send_item(OP_PUSH, ts, ID_W'($urandom), 1'($urandom_range(1)));
			else
				send_item(OP_POP, ts, ID_W'($urandom), $urandom_range(3) == 0);
		end
	endtask

	initial begin
		phase_thr = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd3, 4'd5};
		phase_thr[4] = THR_W'($urandom_range(7, 2));
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset threshold, empty pops, ties and a full store
		send_item(OP_POP, '0, '0, 1'b1);
		send_item(OP_POP, TS_MAX, '1, 1'b0);
		send_item(OP_PUSH, TS_MAX, 16'hffff, 1'b0);
		send_item(OP_PUSH, '0, 16'h0000, 1'b1);
		send_item(OP_PUSH, '0, 16'h0001, 1'b0);
		send_item(OP_POP, '0, '0, 1'b0);
		send_item(OP_POP, TS_MAX, 16'h5a5a, 1'b1);
		for (int k = 0; k < 6; k++)
			send_item(OP_PUSH, TS_W'(1000 - 100 * k), ID_W'(k + 2), 1'b0);
		send_item(OP_PUSH, TS_W'(5), 16'habcd, 1'b0);
		send_item(OP_POP, '0, '0, 1'b0);
		send_item(OP_PUSH, TS_MAX, 16'h1234, 1'b0);
		set_threshold(4'd0);
		send_item(OP_POP, '0, '0, 1'b0);
		set_threshold(4'd15);
		send_item(OP_POP, '0, '0, 1'b0);
		send_item(OP_POP, '0, '0, 1'b1);
		set_threshold(4'd8);
		send_item(OP_POP, '0, '0, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			set_threshold(phase_thr[p]);
			if (p < 2) begin
				send_idle_pct = 17;
				recv_idle_pct = 55;
			end else if (p < 4) begin
				send_idle_pct = 55;
				recv_idle_pct = 17;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_req = ~hold_req;
			end
			random_items(PHASE_ITEMS);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
